>>> sv/spi_ram_pkg.sv
package spi_ram_pkg;

    // bits per serial frame
    localparam int FRAME_BITS = 16;
    // half-bit counter covers two ticks per frame bit
    localparam int HALF_W     = $clog2(2 * FRAME_BITS);
    localparam int LAST_HALF  = 2 * FRAME_BITS - 1;

    localparam int OP_W       = 2;
    localparam int ADDR_W     = 4;
    localparam int WDATA_W    = 11;
    localparam int MISO_W     = 3;
    localparam int RDATA_W    = 16;

    localparam int ADDR_LSB   = 11;
    localparam logic [31:0] READ_CMD = 32'h0000_807F;

    localparam int IN_FIELDS_W  = ADDR_W + WDATA_W + MISO_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 5 + RDATA_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 2'd0,
        OP_READ   = 2'd1,
        OP_WRITE  = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    typedef struct packed {
        logic [RDATA_W-1:0] read_data;
        logic               done_res;
        logic               busy_res;
        logic               mosi;
        logic               sck;
        logic               cs_n;
    } t_result;

endpackage

>>> sv/spi_register_access_master_core.sv
// SPI master for 16-bit register accesses, driven one half-bit tick per input
// transfer. Every accepted transfer yields exactly one result transfer carrying
// the pin levels (cs_n, sck, mosi), busy/done flags and the last read word.
// A transfer is taken every clock cycle as long as the result side keeps up;
// the state update is a single pass of logic from the state registers into the
// result register, and a one-entry skid buffer behind that register lets one
// more transfer be taken when the result side stalls. A write takes
// 32 ticks, a read of address 0 takes 32 ticks, a read of any other address
// takes 65 ticks (two frames and one chip-select gap tick). A start request
// while an access is in progress is ignored and handled as a plain tick.
module spi_register_access_master_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // op
    input  logic [spi_ram_pkg::OP_W-1:0]         s_axis_tuser,
    // reg_addr, write_data, miso_samples, zero pad
    input  logic [spi_ram_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // cs_n, sck, mosi, busy_res, done_res, read_data, zero pad
    output logic [spi_ram_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import spi_ram_pkg::*;

    logic                  r_busy;
    logic                  r_is_read;
    logic [HALF_W-1:0]     r_half;
    logic [1:0]            r_frames;
    logic                  r_gap;
    logic [FRAME_BITS-1:0] r_send;
    logic [FRAME_BITS-1:0] r_recv;
    logic [RDATA_W-1:0]    r_last_read;

    logic                  n_busy;
    logic                  n_is_read;
    logic [HALF_W-1:0]     n_half;
    logic [1:0]            n_frames;
    logic                  n_gap;
    logic [FRAME_BITS-1:0] n_send;
    logic [FRAME_BITS-1:0] n_recv;
    logic [RDATA_W-1:0]    n_last_read;

    t_result               n_res;
    t_result               r_out;
    t_result               r_skid;
    logic                  r_out_valid;
    logic                  r_skid_valid;

    t_op                   in_op;
    logic [ADDR_W-1:0]     in_addr;
    logic [WDATA_W-1:0]    in_wdata;
    logic [MISO_W-1:0]     in_miso;
    logic                  in_accept;
    logic                  out_pop;
    logic                  miso_bit;
    logic [31:0]           read_word;
    logic [31:0]           write_word;
    logic [31:0]           recv_word;

    assign in_op     = t_op'(s_axis_tuser);
    assign in_addr   = s_axis_tdata[ADDR_W-1:0];
    assign in_wdata  = s_axis_tdata[ADDR_W +: WDATA_W];
    assign in_miso   = s_axis_tdata[ADDR_W + WDATA_W +: MISO_W];

    assign s_axis_tready = !r_skid_valid;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_pop       = !r_out_valid || m_axis_tready;

    assign miso_bit   = (in_miso[0] & in_miso[1]) | (in_miso[0] & in_miso[2])
                      | (in_miso[1] & in_miso[2]);
    assign read_word  = READ_CMD | (32'(in_addr) << ADDR_LSB);
    assign write_word = (32'(in_addr) << ADDR_LSB) | 32'(in_wdata);

    always_comb begin
        n_busy      = r_busy;
        n_is_read   = r_is_read;
        n_half      = r_half;
        n_frames    = r_frames;
        n_gap       = r_gap;
        n_send      = r_send;
        n_recv      = r_recv;
        n_last_read = r_last_read;
        recv_word   = '0;
        n_res       = '{read_data: r_last_read, done_res: 1'b0, busy_res: 1'b0,
                        mosi: 1'b1, sck: 1'b0, cs_n: 1'b1};

        // start request, ignored while busy
        if (!r_busy && (in_op == OP_READ || in_op == OP_WRITE)) begin
            n_busy    = 1'b1;
            n_is_read = (in_op == OP_READ);
            n_half    = '0;
            n_gap     = 1'b0;
            n_recv    = '0;
            if (in_op == OP_READ) begin
                if (in_addr != '0) begin
                    n_send   = read_word[FRAME_BITS-1:0];
                    n_frames = 2'd2;
                end else begin
                    n_send   = '1;
                    n_frames = 2'd1;
                end
            end else begin
                n_send   = write_word[FRAME_BITS-1:0];
                n_frames = 2'd1;
            end
        end

        if (n_busy) begin
            n_res.busy_res = 1'b1;
            if (n_gap) begin
                // chip select gap between read frames
                n_gap  = 1'b0;
                n_send = '1;
                n_recv = '0;
                n_half = '0;
            end else begin
                n_res.cs_n = 1'b0;
                n_res.mosi = n_send[FRAME_BITS-1];
                if (!n_half[0]) begin
                    n_res.sck = 1'b1;
                    n_half    = n_half + 1'b1;
                end else begin
                    n_recv = {n_recv[FRAME_BITS-2:0], miso_bit};
                    n_send = {n_send[FRAME_BITS-2:0], 1'b0};
                    if (32'(n_half) >= 32'(LAST_HALF)) begin
                        n_half   = '0;
                        n_frames = n_frames - 1'b1;
                        if (n_frames == 2'd0) begin
                            n_res.done_res = 1'b1;
                            n_busy         = 1'b0;
                            if (n_is_read) begin
                                recv_word   = 32'(n_recv);
                                n_last_read = recv_word[RDATA_W-1:0];
                            end
                        end else begin
                            n_gap = 1'b1;
                        end
                    end else begin
                        n_half = n_half + 1'b1;
                    end
                end
            end
        end
        n_res.read_data = n_last_read;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_is_read    <= 1'b0;
            r_half       <= '0;
            r_frames     <= '0;
            r_gap        <= 1'b0;
            r_send       <= '1;
            r_recv       <= '0;
            r_last_read  <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_busy      <= n_busy;
                r_is_read   <= n_is_read;
                r_half      <= n_half;
                r_frames    <= n_frames;
                r_gap       <= n_gap;
                r_send      <= n_send;
                r_recv      <= n_recv;
                r_last_read <= n_last_read;
            end
            if (out_pop) begin
                if (r_skid_valid) begin
                    r_out        <= r_skid;
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out       <= n_res;
                    r_out_valid <= in_accept;
                end
            end else if (in_accept) begin
                // result side stalled, park the transfer
                r_skid       <= n_res;
                r_skid_valid <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out);

    property p_skid_behind_out;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid;
    endproperty
    a_skid_behind_out: assert property (p_skid_behind_out)
        else $error("skid entry held with empty output register");

    property p_gap_only_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_gap |-> (r_busy && r_is_read && r_frames == 2'd1);
    endproperty
    a_gap_only_busy: assert property (p_gap_only_busy)
        else $error("gap pending outside a two-frame read");

    property p_done_ends_access;
        @(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && n_res.done_res) |=> !r_busy;
    endproperty
    a_done_ends_access: assert property (p_done_ends_access)
        else $error("access still busy after completing tick");

    property p_cs_low_when_busy;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.cs_n) |-> r_out.busy_res;
    endproperty
    a_cs_low_when_busy: assert property (p_cs_low_when_busy)
        else $error("chip select low outside an access");

    property p_frames_nonzero;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_frames != 2'd0);
    endproperty
    a_frames_nonzero: assert property (p_frames_nonzero)
        else $error("busy with no frames left");

endmodule

>>> tb/sv/spi_register_access_master_core_tb.sv
`timescale 1ns / 1ps

module spi_register_access_master_core_tb;

    import spi_ram_pkg::*;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int RAND_PER_PASS = 430;
    localparam int LONG_HOLD     = 120;
    localparam int DRAIN_CYCLES  = 16;
    localparam int REPORT_MAX    = 10;

    localparam t_result IDLE_PINS = '{read_data: '0, done_res: 1'b0, busy_res: 1'b0,
                                      mosi: 1'b1, sck: 1'b0, cs_n: 1'b1};
    // first half-bit of a write: bit 15 is always clear
    localparam t_result WRITE_FIRST = '{read_data: '0, done_res: 1'b0, busy_res: 1'b1,
                                        mosi: 1'b0, sck: 1'b1, cs_n: 1'b0};

    typedef struct {
        t_op                op;
        logic [ADDR_W-1:0]  addr;
        logic [WDATA_W-1:0] data;
        logic [MISO_W-1:0]  miso;
        bit                 typed;
        t_result            pins;
    } t_tick_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OP_W-1:0]        s_axis_tuser = '0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    spi_register_access_master_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // shadow of the serial engine
    bit                    sh_busy = 1'b0;
    bit                    sh_is_read = 1'b0;
    logic [5:0]            sh_half = '0;
    logic [1:0]            sh_frames_left = '0;
    bit                    sh_gap = 1'b0;
    logic [FRAME_BITS-1:0] sh_tx_word = '1;
    logic [FRAME_BITS-1:0] sh_rx_word = '0;
    logic [RDATA_W-1:0]    sh_read_word = '0;

    t_result pin_results_q[$];

    int tx_idle = 0;
    int rx_idle = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int ticks_sent = 0;
    int results_seen = 0;
    int accesses_done = 0;
    int gap_ticks = 0;

    task automatic spi_pins_predict(input t_op op, input logic [ADDR_W-1:0] addr,
                                    input logic [WDATA_W-1:0] data,
                                    input logic [MISO_W-1:0] miso, output t_result pins);
        logic miso_bit;
        miso_bit = (miso[0] & miso[1]) | (miso[0] & miso[2]) | (miso[1] & miso[2]);
        pins = IDLE_PINS;
        if (!sh_busy && (op == OP_READ || op == OP_WRITE)) begin
            sh_busy    = 1'b1;
            sh_is_read = (op == OP_READ);
            sh_half    = '0;
            sh_gap     = 1'b0;
            sh_rx_word = '0;
            if (sh_is_read) begin
                if (addr != '0) begin
                    sh_tx_word     = FRAME_BITS'(READ_CMD | (32'(addr) << ADDR_LSB));
                    sh_frames_left = 2'd2;
                end else begin
                    sh_tx_word     = '1;
                    sh_frames_left = 2'd1;
                end
            end else begin
                sh_tx_word     = FRAME_BITS'((32'(addr) << ADDR_LSB) | 32'(data));
                sh_frames_left = 2'd1;
            end
        end
        if (sh_busy) begin
            pins.busy_res = 1'b1;
            if (sh_gap) begin
                // chip select gap between the two frames of a read
                sh_gap     = 1'b0;
                sh_tx_word = '1;
                sh_rx_word = '0;
                sh_half    = '0;
                gap_ticks++;
            end else begin
                pins.cs_n = 1'b0;
                pins.mosi = sh_tx_word[FRAME_BITS-1];
                if (!sh_half[0]) begin
                    pins.sck = 1'b1;
                    sh_half  = sh_half + 6'd1;
                end else begin
                    sh_rx_word = {sh_rx_word[FRAME_BITS-2:0], miso_bit};
                    sh_tx_word = sh_tx_word << 1;
                    if (sh_half >= LAST_HALF) begin
                        sh_half        = '0;
                        sh_frames_left = sh_frames_left - 2'd1;
                        if (sh_frames_left == '0) begin
                            pins.done_res = 1'b1;
                            sh_busy       = 1'b0;
                            accesses_done++;
                            if (sh_is_read)
                                sh_read_word = RDATA_W'(sh_rx_word);
                        end else begin
                            sh_gap = 1'b1;
                        end
                    end else begin
                        sh_half = sh_half + 6'd1;
                    end
                end
            end
        end
        pins.read_data = sh_read_word;
    endtask

    task automatic send_tick(input t_op op, input logic [ADDR_W-1:0] addr,
                             input logic [WDATA_W-1:0] data, input logic [MISO_W-1:0] miso,
                             input bit typed, input t_result typed_pins);
        t_result pins;
        while ($urandom_range(99) < tx_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_TDATA_W'({miso, data, addr});
        do @(posedge i_clk); while (!s_axis_tready);
        spi_pins_predict(op, addr, data, miso, pins);
        pin_results_q.push_back(typed ? typed_pins : pins);
        ticks_sent++;
    endtask

    task automatic report_mismatch(input string what, input t_result want,
                                   input t_result got);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("[%0t] %s: expected cs_n=%b sck=%b mosi=%b busy=%b done=%b rd=%h",
                     $realtime, what, want.cs_n, want.sck, want.mosi, want.busy_res,
                     want.done_res, want.read_data);
            $display("    got cs_n=%b sck=%b mosi=%b busy=%b done=%b rd=%h",
                     got.cs_n, got.sck, got.mosi, got.busy_res, got.done_res,
                     got.read_data);
        end
    endtask

    // result side: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_requests) begin
            hold_seen     <= hold_requests;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[OUT_FIELDS_W-1:0]);
            results_seen++;
            if (pin_results_q.size() == 0) begin
                report_mismatch("result with nothing pending", IDLE_PINS, got);
            end else begin
                want = pin_results_q.pop_front();
                if (got.cs_n !== want.cs_n || got.sck !== want.sck ||
                        got.mosi !== want.mosi || got.busy_res !== want.busy_res ||
                        got.done_res !== want.done_res || got.read_data !== want.read_data)
                    report_mismatch("pin mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     pin_results_q.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin : stimulus
        t_tick_row tick_tab [18];
        t_op               op;
        logic [ADDR_W-1:0] addr;
        int                pick;

        tick_tab = '{
            '{OP_TICK,   4'h0, 11'h000, 3'b000, 1'b1, IDLE_PINS},
            '{OP_UNUSED, 4'hF, 11'h7FF, 3'b111, 1'b1, IDLE_PINS},
            '{OP_TICK,   4'hF, 11'h7FF, 3'b111, 1'b1, IDLE_PINS},
            '{OP_WRITE,  4'hF, 11'h7FF, 3'b000, 1'b1, WRITE_FIRST},
            // start requests while busy must be ignored
            '{OP_READ,   4'h5, 11'h555, 3'b111, 1'b0, IDLE_PINS},
            '{OP_WRITE,  4'h0, 11'h000, 3'b001, 1'b0, IDLE_PINS},
            '{OP_READ,   4'h0, 11'h2AA, 3'b010, 1'b0, IDLE_PINS},
            '{OP_UNUSED, 4'hA, 11'h2AA, 3'b011, 1'b0, IDLE_PINS},
            '{OP_TICK,   4'h0, 11'h000, 3'b100, 1'b0, IDLE_PINS},
            '{OP_TICK,   4'h0, 11'h000, 3'b101, 1'b0, IDLE_PINS},
            '{OP_TICK,   4'h0, 11'h000, 3'b110, 1'b0, IDLE_PINS},
            '{OP_TICK,   4'h0, 11'h000, 3'b111, 1'b0, IDLE_PINS},
            '{OP_TICK,   4'h0, 11'h000, 3'b000, 1'b0, IDLE_PINS},
            '{OP_TICK,   4'h0, 11'h000, 3'b001, 1'b0, IDLE_PINS},
            '{OP_TICK,   4'h0, 11'h000, 3'b010, 1'b0, IDLE_PINS},
            '{OP_TICK,   4'h0, 11'h000, 3'b100, 1'b0, IDLE_PINS},
            '{OP_TICK,   4'h0, 11'h000, 3'b011, 1'b0, IDLE_PINS},
            '{OP_TICK,   4'h0, 11'h000, 3'b110, 1'b0, IDLE_PINS}
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle = 21;
        rx_idle = 68;
        foreach (tick_tab[i])
            send_tick(tick_tab[i].op, tick_tab[i].addr, tick_tab[i].data, tick_tab[i].miso,
                      tick_tab[i].typed, tick_tab[i].pins);

        for (int pass = 0; pass < 3; pass++) begin
            tx_idle = (pass == 0) ? 21 : (pass == 1) ? 68 : 0;
            rx_idle = (pass == 0) ? 68 : (pass == 1) ? 21 : 0;
            for (int k = 0; k < RAND_PER_PASS; k++) begin
                // back up the result side while inputs keep coming
                if (pass == 2 && k == 150)
                    hold_requests++;
                pick = $urandom_range(99);
                if (!sh_busy) begin
                    if (pick < 70)
                        op = $urandom_range(1) ? OP_READ : OP_WRITE;
                    else if (pick < 88)
                        op = OP_TICK;
                    else
                        op = OP_UNUSED;
                end else begin
                    if (pick < 90)
                        op = OP_TICK;
                    else if (pick < 94)
                        op = OP_READ;
                    else if (pick < 97)
                        op = OP_WRITE;
                    else
                        op = OP_UNUSED;
                end
                addr = ($urandom_range(3) == 0) ? '0 : ADDR_W'($urandom_range(15));
                send_tick(op, addr, WDATA_W'($urandom_range(2047)),
                          MISO_W'($urandom_range(7)), 1'b0, IDLE_PINS);
            end
            // hold the input until every pending result is out
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while (pin_results_q.size() != 0)
                @(posedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d ticks, checked %0d results over %0d completed accesses",
                 ticks_sent, results_seen, accesses_done);
        $display("%0d chip-select gaps in two-frame reads, %0d mismatches", gap_ticks,
                 mismatches);
        if (mismatches == 0 && pin_results_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
